// ===== rtl/assert_macros.svh =====
// assertion macros, included by min_window_multiset_match
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// plain concurrent property on a clock, off while reset is held
`define ASSERT_PROP(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("assertion failed");

// overlapping implication on a clock, off while reset is held
`define ASSERT_IMPLY(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("assertion failed");

`else

`define ASSERT_PROP(label, clk, rstn, prop)
`define ASSERT_IMPLY(label, clk, rstn, pre, post)

`endif

`endif

// ===== rtl/mwm_pkg.sv =====
// shared types and constants of the minimum window multiset matcher
// no dependencies; used by every module of the block
package mwm_pkg;

    localparam int MAX_TEXT = 1024;
    localparam int ALPHABET = 256;

    localparam int ADDR_W = $clog2(MAX_TEXT);
    localparam int CNT_W  = $clog2(MAX_TEXT) + 1;
    localparam int TBL_W  = $clog2(ALPHABET);
    localparam int SYM_W  = 8;
    localparam int OP_W   = 2;

    localparam int OUT_W      = 1 + ADDR_W + CNT_W + 1;
    localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_PATTERN = 2'd0,
        OP_TEXT    = 2'd1,
        OP_END     = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAT_UPD,
        ST_TXT_UPD,
        ST_FETCH,
        ST_LOOK,
        ST_TEST,
        ST_RECORD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [TBL_W-1:0] rd_addr;
        logic [TBL_W-1:0] wr_addr;
        logic [CNT_W-1:0] wdata;
        logic             need_we;
        logic             win_we;
        logic             clear;
    } tbl_ctrl_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [SYM_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr;
    } txt_ctrl_t;

    typedef struct packed {
        logic              overflow;
        logic [CNT_W-1:0]  best_length;
        logic [ADDR_W-1:0] best_start;
        logic              found;
    } result_t;

endpackage

// ===== rtl/mwm_tables.sv =====
// need and window count tables, one read and one write port each
// depends on mwm_pkg; entries read as zero until written after a clear
module mwm_tables import mwm_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  tbl_ctrl_t        ctl,
    output logic [CNT_W-1:0] need_q,
    output logic [CNT_W-1:0] win_q
);

    logic [CNT_W-1:0] need_mem [ALPHABET];
    logic [CNT_W-1:0] win_mem  [ALPHABET];

    logic [ALPHABET-1:0] need_vld_reg;
    logic [ALPHABET-1:0] win_vld_reg;
    logic [CNT_W-1:0]    need_rd_reg;
    logic [CNT_W-1:0]    win_rd_reg;
    logic                need_rd_vld_reg;
    logic                win_rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (ctl.need_we) begin
            need_mem[ctl.wr_addr] <= ctl.wdata;
        end
        if (ctl.win_we) begin
            win_mem[ctl.wr_addr] <= ctl.wdata;
        end
        need_rd_reg <= need_mem[ctl.rd_addr];
        win_rd_reg  <= win_mem[ctl.rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            need_vld_reg    <= '0;
            win_vld_reg     <= '0;
            need_rd_vld_reg <= 1'b0;
            win_rd_vld_reg  <= 1'b0;
        end else begin
            need_rd_vld_reg <= need_vld_reg[ctl.rd_addr];
            win_rd_vld_reg  <= win_vld_reg[ctl.rd_addr];
            if (ctl.clear) begin
                need_vld_reg <= '0;
                win_vld_reg  <= '0;
            end else begin
                if (ctl.need_we) begin
                    need_vld_reg[ctl.wr_addr] <= 1'b1;
                end
                if (ctl.win_we) begin
                    win_vld_reg[ctl.wr_addr] <= 1'b1;
                end
            end
        end
    end

    assign need_q = need_rd_vld_reg ? need_rd_reg : '0;
    assign win_q  = win_rd_vld_reg ? win_rd_reg : '0;

endmodule

// ===== rtl/mwm_text_ram.sv =====
// text byte store, one write and one registered read port
// depends on mwm_pkg; contents undefined until written
module mwm_text_ram import mwm_pkg::*; (
    input  logic             aclk,
    input  txt_ctrl_t        ctl,
    output logic [SYM_W-1:0] rdata
);

    logic [SYM_W-1:0] mem [MAX_TEXT];
    logic [SYM_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            mem[ctl.waddr] <= ctl.wdata;
        end
        rdata_reg <= mem[ctl.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mwm_ctrl.sv =====
// sequencer and shared count unit of the window matcher
// depends on mwm_pkg; drives mwm_tables and mwm_text_ram
module mwm_ctrl import mwm_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic [OP_W-1:0]  in_op,
    input  logic [SYM_W-1:0] in_sym,
    output logic             in_ready,
    output tbl_ctrl_t        tbl,
    input  logic [CNT_W-1:0] need_q,
    input  logic [CNT_W-1:0] win_q,
    output txt_ctrl_t        txt,
    input  logic [SYM_W-1:0] txt_q,
    input  logic             out_free,
    output logic             emit,
    output result_t          res
);

    state_t            state_reg, state_next;
    logic [TBL_W-1:0]  sym_reg, sym_next;
    logic [CNT_W-1:0]  pat_reg, pat_next;
    logic [CNT_W-1:0]  matched_reg, matched_next;
    logic [CNT_W-1:0]  wp_reg, wp_next;
    logic [ADDR_W-1:0] left_reg, left_next;
    logic [ADDR_W-1:0] best_begin_reg, best_begin_next;
    logic [CNT_W-1:0]  best_span_reg, best_span_next;
    logic              dropped_reg, dropped_next;

    logic             accept;
    op_t              op;
    logic [CNT_W-1:0] alu_in;
    logic [CNT_W-1:0] alu_out;
    logic             surplus;
    logic             text_full;
    logic             pat_full;
    logic [CNT_W-1:0] win_len;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign op        = op_t'(in_op);
    assign text_full = (wp_reg >= CNT_W'(MAX_TEXT));
    assign pat_full  = (pat_reg >= CNT_W'(MAX_TEXT));
    assign surplus   = (win_q > need_q);
    assign win_len   = wp_reg - {1'b0, left_reg};

    // shared counter unit: increments need or window counts, decrements on shrink
    assign alu_in  = (state_reg == ST_PAT_UPD) ? need_q : win_q;
    assign alu_out = (state_reg == ST_TEST) ? (alu_in - CNT_W'(1)) : (alu_in + CNT_W'(1));

    always_comb begin
        sym_next        = sym_reg;
        pat_next        = pat_reg;
        matched_next    = matched_reg;
        wp_next         = wp_reg;
        left_next       = left_reg;
        best_begin_next = best_begin_reg;
        best_span_next  = best_span_reg;
        dropped_next    = dropped_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (op)
                        OP_PATTERN: begin
                            if (wp_reg == '0) begin
                                if (pat_full) begin
                                    dropped_next = 1'b1;
                                end else begin
                                    sym_next = in_sym[TBL_W-1:0];
                                end
                            end
                        end
                        OP_TEXT: begin
                            if (text_full) begin
                                dropped_next = 1'b1;
                            end else begin
                                sym_next = in_sym[TBL_W-1:0];
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_PAT_UPD: begin
                pat_next = pat_reg + CNT_W'(1);
            end
            ST_TXT_UPD: begin
                matched_next = matched_reg + CNT_W'(alu_out <= need_q);
                wp_next      = wp_reg + CNT_W'(1);
            end
            ST_LOOK: begin
                sym_next = txt_q[TBL_W-1:0];
            end
            ST_TEST: begin
                if (surplus) begin
                    left_next = left_reg + ADDR_W'(1);
                end
            end
            ST_RECORD: begin
                if (best_span_reg == '0 || win_len < best_span_reg) begin
                    best_span_next  = win_len;
                    best_begin_next = left_reg;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    pat_next        = '0;
                    matched_next    = '0;
                    wp_next         = '0;
                    left_next       = '0;
                    best_begin_next = '0;
                    best_span_next  = '0;
                    dropped_next    = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (op)
                        OP_PATTERN: begin
                            if (wp_reg == '0 && !pat_full) begin
                                state_next = ST_PAT_UPD;
                            end
                        end
                        OP_TEXT: begin
                            if (!text_full) begin
                                state_next = ST_TXT_UPD;
                            end
                        end
                        OP_END:  state_next = ST_EMIT;
                        default: ;
                    endcase
                end
            end
            ST_PAT_UPD: state_next = ST_IDLE;
            ST_TXT_UPD: begin
                if (pat_reg != '0 && matched_next == pat_reg) begin
                    state_next = ST_FETCH;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH: begin
                if ({1'b0, left_reg} < wp_reg) begin
                    state_next = ST_LOOK;
                end else begin
                    state_next = ST_RECORD;
                end
            end
            ST_LOOK: state_next = ST_TEST;
            ST_TEST: begin
                if (surplus) begin
                    state_next = ST_FETCH;
                end else begin
                    state_next = ST_RECORD;
                end
            end
            ST_RECORD: state_next = ST_IDLE;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        tbl.rd_addr = (state_reg == ST_LOOK) ? txt_q[TBL_W-1:0] : in_sym[TBL_W-1:0];
        tbl.wr_addr = sym_reg;
        tbl.wdata   = alu_out;
        tbl.need_we = (state_reg == ST_PAT_UPD);
        tbl.win_we  = (state_reg == ST_TXT_UPD) || ((state_reg == ST_TEST) && surplus);
        tbl.clear   = (state_reg == ST_EMIT) && out_free;

        txt.we    = accept && (op == OP_TEXT) && !text_full;
        txt.waddr = wp_reg[ADDR_W-1:0];
        txt.wdata = in_sym;
        txt.raddr = left_reg;

        emit            = (state_reg == ST_EMIT) && out_free;
        res.found       = (best_span_reg != '0);
        res.best_start  = res.found ? best_begin_reg : '0;
        res.best_length = res.found ? best_span_reg : '0;
        res.overflow    = dropped_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pat_reg        <= '0;
            matched_reg    <= '0;
            wp_reg         <= '0;
            left_reg       <= '0;
            best_begin_reg <= '0;
            best_span_reg  <= '0;
            dropped_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pat_reg        <= pat_next;
            matched_reg    <= matched_next;
            wp_reg         <= wp_next;
            left_reg       <= left_next;
            best_begin_reg <= best_begin_next;
            best_span_reg  <= best_span_next;
            dropped_reg    <= dropped_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg <= sym_next;
    end

endmodule

// ===== rtl/min_window_multiset_match.sv =====
// channel  | ports            | payload
// input    | s_tvalid/s_tready | s_tuser: operation; s_tdata: symbol
// result   | m_tvalid/m_tready | m_tdata: found, best_start, best_length, overflow
//
// pattern byte: count table read, then write of the incremented count
// text byte: window count read, then write of the incremented count; once the window holds the pattern,
//   fetch, look and test steps per left-edge byte, then a record step, all through the count tables and text store
// end item: held in the emit step while the previous result waits in the output register
// aresetn clears control state and the table valid bits at once; no clearing pass
// s_tready is low while an item is being worked on
`include "assert_macros.svh"

module min_window_multiset_match import mwm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SYM_W-1:0]      s_tdata,   // symbol
    input  logic [OP_W-1:0]       s_tuser,   // operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // found, best_start, best_length, overflow
);

    tbl_ctrl_t        tbl;
    txt_ctrl_t        txt;
    logic [CNT_W-1:0] need_q;
    logic [CNT_W-1:0] win_q;
    logic [SYM_W-1:0] txt_q;
    logic             out_free;
    logic             emit;
    result_t          res;

    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    mwm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_sym   (s_tdata),
        .in_ready (s_tready),
        .tbl      (tbl),
        .need_q   (need_q),
        .win_q    (win_q),
        .txt      (txt),
        .txt_q    (txt_q),
        .out_free (out_free),
        .emit     (emit),
        .res      (res)
    );

    mwm_tables u_tables (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (tbl),
        .need_q  (need_q),
        .win_q   (win_q)
    );

    mwm_text_ram u_text (
        .aclk  (aclk),
        .ctl   (txt),
        .rdata (txt_q)
    );

    // output register, free again in the cycle its transfer completes
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= OUT_DATA_W'(res);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    logic              out_found;
    logic [ADDR_W-1:0] out_start;
    logic [CNT_W-1:0]  out_len;
    logic [CNT_W:0]    out_end;

    assign out_found = m_tdata_reg[0];
    assign out_start = m_tdata_reg[ADDR_W:1];
    assign out_len   = m_tdata_reg[ADDR_W+CNT_W:ADDR_W+1];
    assign out_end   = (CNT_W+1)'(out_start) + (CNT_W+1)'(out_len);

    `ASSERT_IMPLY(a_none_is_zero, aclk, aresetn, m_tvalid_reg && !out_found, out_start == '0 && out_len == '0)
    `ASSERT_IMPLY(a_window_in_text, aclk, aresetn, m_tvalid_reg && out_found, out_len != '0 && out_end <= (CNT_W+1)'(MAX_TEXT))
    `ASSERT_PROP(a_end_busy, aclk, aresetn, s_tvalid && s_tready && s_tuser == OP_END |=> !s_tready)

endmodule
